/* rtl/core/dmalu_pkg.sv */
// Package for the decimal mantissa ALU: field widths, opcodes, status and
// order codes, and the stage-one result type. No dependencies.
package dmalu_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MANT_W  = 3 * WORD_W;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned REM_W   = 4;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned OP_W    = 3;

  localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(28);
  localparam logic [REM_W-1:0]   MAX_REM   = REM_W'(9);

  // floor(2^96 / 10) + 1: the mantissa left after a round-up that overflows
  localparam logic [MANT_W-1:0] ROUND_OVF_MANT = 96'h1999_9999_9999_9999_9999_999A;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_CMP   = 3'd2,
    OP_MUL10 = 3'd3,
    OP_DIV10 = 3'd4,
    OP_ROUND = 3'd5
  } opcode_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_NEG_OVF = 2'd2;

  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  // Result of the first stage; use_div selects the quotient path at the end
  typedef struct packed {
    logic [MANT_W-1:0]  mant;
    logic [SCALE_W-1:0] scale;
    logic [1:0]         order;
    logic [1:0]         status;
    logic               use_div;
  } alu_res_t;

endpackage

/* rtl/core/dmalu_in_if.sv */
// Input channel of the decimal mantissa ALU: valid/ready plus operand item.
// Depends on dmalu_pkg.
interface dmalu_in_if import dmalu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic [WORD_W-1:0]         a_word0;
  logic [WORD_W-1:0]         a_word1;
  logic [WORD_W-1:0]         a_word2;
  logic [WORD_W-1:0]         b_word0;
  logic [WORD_W-1:0]         b_word1;
  logic [WORD_W-1:0]         b_word2;
  logic [SCALE_W-1:0]        scale_in;
  logic                      negative_in;
  logic signed [DIGIT_W-1:0] round_digit;
  logic [REM_W-1:0]          remainder_in;

  modport source (
    output valid, opcode, a_word0, a_word1, a_word2, b_word0, b_word1, b_word2,
           scale_in, negative_in, round_digit, remainder_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, a_word0, a_word1, a_word2, b_word0, b_word1, b_word2,
           scale_in, negative_in, round_digit, remainder_in,
    output ready
  );
endinterface

/* rtl/core/dmalu_out_if.sv */
// Result channel of the decimal mantissa ALU: valid/ready plus result item.
// Depends on dmalu_pkg.
interface dmalu_out_if import dmalu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  res_word0;
  logic [WORD_W-1:0]  res_word1;
  logic [WORD_W-1:0]  res_word2;
  logic [SCALE_W-1:0] scale_out;
  logic [REM_W-1:0]   remainder_out;
  logic signed [1:0]  order;
  logic [1:0]         status;

  modport source (
    output valid, res_word0, res_word1, res_word2, scale_out, remainder_out,
           order, status,
    input  ready
  );
  modport sink (
    input  valid, res_word0, res_word1, res_word2, scale_out, remainder_out,
           order, status,
    output ready
  );
endinterface

/* rtl/core/dmalu_div_step.sv */
// One word of the long division by ten, done as two 16-bit digit steps.
// Depends on dmalu_pkg.
module dmalu_div_step import dmalu_pkg::*; (
  input  logic [REM_W-1:0]  rem_i,
  input  logic [WORD_W-1:0] word_i,
  output logic [WORD_W-1:0] quot_o,
  output logic [REM_W-1:0]  rem_o
);

  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned T_W     = HALF_W + REM_W;
  localparam int unsigned SHIFT   = T_W + 3;
  localparam int unsigned PROD_W  = 2 * T_W;
  localparam int unsigned Q_W     = PROD_W - SHIFT;
  localparam logic [T_W-1:0] RECIP = T_W'((64'd1 << SHIFT) / 10);
  localparam logic [T_W-1:0] TEN   = T_W'(10);

  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] r;
  } chunk_t;

  // reciprocal estimate is exact or one short; one correction fixes it
  function automatic chunk_t div_chunk(logic [REM_W-1:0] r_in, logic [HALF_W-1:0] c);
    logic [T_W-1:0]    t;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q0;
    logic [T_W-1:0]    r0;
    chunk_t            res;
    t    = {r_in, c};
    prod = PROD_W'(t) * PROD_W'(RECIP);
    q0   = prod[PROD_W-1:SHIFT];
    // q0 * 10 never exceeds t, so it fits the T_W-bit product
    r0   = t - (T_W'(q0) * TEN);
    if (r0 >= TEN) begin
      res.q = q0 + Q_W'(1);
      res.r = REM_W'(r0 - TEN);
    end else begin
      res.q = q0;
      res.r = REM_W'(r0);
    end
    return res;
  endfunction

  chunk_t hi, lo;

  always_comb begin
    hi     = div_chunk(rem_i, word_i[WORD_W-1:HALF_W]);
    lo     = div_chunk(hi.r, word_i[HALF_W-1:0]);
    // bit HALF_W of the upper quotient only appears past the 96-bit range
    quot_o = {hi.q[HALF_W-1:0], lo.q[HALF_W-1:0]};
    rem_o  = lo.r;
  end

endmodule

/* rtl/core/dmalu_arith.sv */
// First-stage arithmetic: add, subtract, compare, times ten, round and the
// divide control decision. Depends on dmalu_pkg.
module dmalu_arith import dmalu_pkg::*; (
  input  logic [OP_W-1:0]           opcode_i,
  input  logic [MANT_W-1:0]         a_i,
  input  logic [MANT_W-1:0]         b_i,
  input  logic [SCALE_W-1:0]        scale_i,
  input  logic                      negative_i,
  input  logic signed [DIGIT_W-1:0] round_digit_i,
  input  logic [REM_W-1:0]          remainder_i,
  output alu_res_t                  res_o
);

  logic [MANT_W:0]     sum, diff, inc, dec;
  logic [MANT_W+3:0]   times10;
  logic [DIGIT_W-1:0]  digit_u, mag;
  logic                bump;

  always_comb begin
    sum     = {1'b0, a_i} + {1'b0, b_i};
    diff    = {1'b0, a_i} - {1'b0, b_i};
    inc     = {1'b0, a_i} + (MANT_W+1)'(1);
    dec     = {1'b0, a_i} - (MANT_W+1)'(1);
    times10 = ({4'd0, a_i} << 3) + ({4'd0, a_i} << 1);
    digit_u = round_digit_i;
    mag     = round_digit_i[DIGIT_W-1] ? (DIGIT_W'(0) - digit_u) : digit_u;
    bump    = (mag > DIGIT_W'(5)) || ((mag == DIGIT_W'(5)) && a_i[0]);

    res_o.mant    = a_i;
    res_o.scale   = scale_i;
    res_o.order   = ORD_EQ;
    res_o.status  = ST_OK;
    res_o.use_div = 1'b0;

    case (opcode_e'(opcode_i))
      OP_ADD: begin
        res_o.mant   = sum[MANT_W-1:0];
        res_o.status = sum[MANT_W] ? ST_ERR : ST_OK;
      end
      OP_SUB: begin
        res_o.mant   = diff[MANT_W-1:0];
        res_o.status = diff[MANT_W] ? ST_ERR : ST_OK;
      end
      OP_CMP: begin
        if (a_i == b_i) begin
          res_o.order = ORD_EQ;
        end else if (diff[MANT_W]) begin
          res_o.order = ORD_LT;
        end else begin
          res_o.order = ORD_GT;
        end
      end
      OP_MUL10: begin
        if ((scale_i >= MAX_SCALE) || (|times10[MANT_W+3:MANT_W])) begin
          res_o.status = ST_ERR;
        end else begin
          res_o.mant  = times10[MANT_W-1:0];
          res_o.scale = scale_i + SCALE_W'(1);
        end
      end
      OP_DIV10: begin
        if (scale_i == '0) begin
          res_o.status = ST_ERR;
        end else begin
          res_o.use_div = 1'b1;
          res_o.scale   = scale_i - SCALE_W'(1);
          res_o.status  = (remainder_i > MAX_REM) ? ST_ERR : ST_OK;
        end
      end
      OP_ROUND: begin
        if (bump) begin
          if (round_digit_i[DIGIT_W-1]) begin
            res_o.mant = dec[MANT_W-1:0];
          end else if (!inc[MANT_W]) begin
            res_o.mant = inc[MANT_W-1:0];
          end else if (scale_i != '0) begin
            res_o.mant  = ROUND_OVF_MANT;
            res_o.scale = scale_i - SCALE_W'(1);
          end else begin
            res_o.mant   = '0;
            res_o.status = negative_i ? ST_NEG_OVF : ST_ERR;
          end
        end
      end
      default: begin
        res_o.mant   = '0;
        res_o.scale  = '0;
        res_o.status = ST_ERR;
      end
    endcase
  end

endmodule

/* rtl/core/decimal_mantissa_alu.sv */
// Decimal mantissa ALU: three register stages, one item per cycle sustained
// while results are taken. The divide by ten is the long pole: one 32-bit
// word of quotient per stage, two 16-bit digit steps each.
// A full output register stalls every stage together; nothing is dropped.
// Reset (rst_ni, async, active low) clears only the stage valid bits.
module decimal_mantissa_alu import dmalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmalu_in_if.sink    in_i,
  dmalu_out_if.source res_o
);

  // pipeline advance: all stages move unless the output item is held
  logic advance;
  assign advance  = !res_o.valid || res_o.ready;
  assign in_i.ready = advance;

  // ---------------- stage 1: arithmetic and top quotient word -------------
  alu_res_t          s1_res;
  logic [WORD_W-1:0] s1_q2;
  logic [REM_W-1:0]  s1_rem;

  dmalu_arith u_arith (
    .opcode_i      (in_i.opcode),
    .a_i           ({in_i.a_word2, in_i.a_word1, in_i.a_word0}),
    .b_i           ({in_i.b_word2, in_i.b_word1, in_i.b_word0}),
    .scale_i       (in_i.scale_in),
    .negative_i    (in_i.negative_in),
    .round_digit_i (in_i.round_digit),
    .remainder_i   (in_i.remainder_in),
    .res_o         (s1_res)
  );

  // remainder_in sits above the top word; a value of ten or more wraps the
  // quotient, which the stage-one status already flags
  dmalu_div_step u_div2 (
    .rem_i  (in_i.remainder_in),
    .word_i (in_i.a_word2),
    .quot_o (s1_q2),
    .rem_o  (s1_rem)
  );

  logic              v1_q, v2_q, v3_q;
  alu_res_t          p1_q, p2_q;
  logic [WORD_W-1:0] q2_1_q, a1_1_q, a0_1_q;
  logic [REM_W-1:0]  rem1_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_q   <= s1_res;
      q2_1_q <= s1_q2;
      rem1_q <= s1_rem;
      a1_1_q <= in_i.a_word1;
      a0_1_q <= in_i.a_word0;
    end
  end

  // ---------------- stage 2: middle quotient word --------------------------
  logic [WORD_W-1:0] s2_q1;
  logic [REM_W-1:0]  s2_rem;

  dmalu_div_step u_div1 (
    .rem_i  (rem1_q),
    .word_i (a1_1_q),
    .quot_o (s2_q1),
    .rem_o  (s2_rem)
  );

  logic [WORD_W-1:0] q2_2_q, q1_2_q, a0_2_q;
  logic [REM_W-1:0]  rem2_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p2_q   <= p1_q;
      q2_2_q <= q2_1_q;
      q1_2_q <= s2_q1;
      rem2_q <= s2_rem;
      a0_2_q <= a0_1_q;
    end
  end

  // ---------------- stage 3: low quotient word and result select -----------
  logic [WORD_W-1:0] s3_q0;
  logic [REM_W-1:0]  s3_rem;

  dmalu_div_step u_div0 (
    .rem_i  (rem2_q),
    .word_i (a0_2_q),
    .quot_o (s3_q0),
    .rem_o  (s3_rem)
  );

  logic [MANT_W-1:0]  mant_d, mant_q;
  logic [REM_W-1:0]   rem_out_d, rem_out_q;
  logic [SCALE_W-1:0] scale_q;
  logic [1:0]         order_q, status_q;

  always_comb begin
    if (p2_q.use_div) begin
      mant_d    = {q2_2_q, q1_2_q, s3_q0};
      rem_out_d = s3_rem;
    end else begin
      mant_d    = p2_q.mant;
      rem_out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mant_q    <= mant_d;
      rem_out_q <= rem_out_d;
      scale_q   <= p2_q.scale;
      order_q   <= p2_q.order;
      status_q  <= p2_q.status;
    end
  end

  // valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign res_o.valid         = v3_q;
  assign res_o.res_word0     = mant_q[WORD_W-1:0];
  assign res_o.res_word1     = mant_q[2*WORD_W-1:WORD_W];
  assign res_o.res_word2     = mant_q[MANT_W-1:2*WORD_W];
  assign res_o.scale_out     = scale_q;
  assign res_o.remainder_out = rem_out_q;
  assign res_o.order         = order_q;
  assign res_o.status        = status_q;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for decimal_mantissa_alu: random and directed items,
// with a scoreboard class that predicts and checks every result.
// Depends on dmalu_pkg, dmalu_in_if, dmalu_out_if and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dmalu_pkg::*;

  // Opcodes the block does not define; they must come back as an error
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic [MANT_W-1:0] MANT_ALL = {MANT_W{1'b1}};
  // Largest mantissa that can still be multiplied by ten
  localparam logic [MANT_W-1:0] MANT_TENTH = MANT_ALL / 96'd10;

  localparam int RANDOM_ITEMS  = 1700;
  localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES   = 8;     // pipeline is three deep

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [MANT_W-1:0]         a;
    logic [MANT_W-1:0]         b;
    logic [SCALE_W-1:0]        scale;
    logic                      negative;
    logic signed [DIGIT_W-1:0] digit;
    logic [REM_W-1:0]          rem_in;
  } op_item_t;

  typedef struct packed {
    logic [MANT_W-1:0]  mant;
    logic [SCALE_W-1:0] scale;
    logic [REM_W-1:0]   rem;
    logic [1:0]         order;
    logic [1:0]         status;
  } alu_result_t;

  // Predicts the result of each accepted item and checks results in order
  class mantissa_checker;
    alu_result_t pending_results[$];
    int          mismatches;

    function alu_result_t compute_result(op_item_t op);
      alu_result_t r;
      logic [MANT_W:0]   sum;
      logic [MANT_W+3:0] wide;
      logic [MANT_W+3:0] quo;
      int                mag;
      r.mant   = op.a;
      r.scale  = op.scale;
      r.rem    = '0;
      r.order  = ORD_EQ;
      r.status = ST_OK;
      case (op.opcode)
        OP_ADD: begin
          sum    = {1'b0, op.a} + {1'b0, op.b};
          r.mant = sum[MANT_W-1:0];
          if (sum[MANT_W]) r.status = ST_ERR;
        end
        OP_SUB: begin
          r.mant = op.a - op.b;
          if (op.a < op.b) r.status = ST_ERR;
        end
        OP_CMP: begin
          if (op.a > op.b) r.order = ORD_GT;
          else if (op.a < op.b) r.order = ORD_LT;
        end
        OP_MUL10: begin
          wide = {4'd0, op.a} * 100'd10;
          if (op.scale >= MAX_SCALE || wide[MANT_W+3:MANT_W] != '0) begin
            r.status = ST_ERR;
          end else begin
            r.mant  = wide[MANT_W-1:0];
            r.scale = op.scale + 1'b1;
          end
        end
        OP_DIV10: begin
          // the carried remainder sits above the top word
          if (op.scale == '0) begin
            r.status = ST_ERR;
          end else begin
            wide    = {op.rem_in, op.a};
            quo     = wide / 100'd10;
            r.mant  = quo[MANT_W-1:0];
            r.rem   = REM_W'(wide % 100'd10);
            r.scale = op.scale - 1'b1;
            if (quo[MANT_W+3:MANT_W] != '0) r.status = ST_ERR;
          end
        end
        OP_ROUND: begin
          mag = (op.digit < 0) ? -int'(op.digit) : int'(op.digit);
          // banker's rounding: a five rounds only an odd mantissa
          if (mag > 5 || (mag == 5 && op.a[0])) begin
            if (op.digit < 0) begin
              r.mant = op.a - 96'd1;
            end else begin
              sum    = {1'b0, op.a} + 97'd1;
              r.mant = sum[MANT_W-1:0];
              if (sum[MANT_W]) begin
                if (op.scale != '0) begin
                  // 2^96 scaled down one decade, rounded up
                  wide    = ({4'd1, {MANT_W{1'b0}}} / 100'd10) + 100'd1;
                  r.mant  = wide[MANT_W-1:0];
                  r.scale = op.scale - 1'b1;
                end else begin
                  r.mant   = '0;
                  r.status = op.negative ? ST_NEG_OVF : ST_ERR;
                end
              end
            end
          end
        end
        default: begin
          r.mant   = '0;
          r.scale  = '0;
          r.status = ST_ERR;
        end
      endcase
      return r;
    endfunction

    function void log_operation(op_item_t op);
      pending_results.push_back(compute_result(op));
    endfunction

    function bit compare_field(string name, logic [MANT_W-1:0] want, logic [MANT_W-1:0] got);
      if (want === got) return 1'b1;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t want;
      bit ok;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no item outstanding, expected none, actual 0x%0h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      ok = 1'b1;
      ok &= compare_field("res_word0", want.mant[31:0], got.mant[31:0]);
      ok &= compare_field("res_word1", want.mant[63:32], got.mant[63:32]);
      ok &= compare_field("res_word2", want.mant[95:64], got.mant[95:64]);
      ok &= compare_field("scale_out", want.scale, got.scale);
      ok &= compare_field("remainder_out", want.rem, got.rem);
      ok &= compare_field("order", want.order, got.order);
      ok &= compare_field("status", want.status, got.status);
      if (!ok) mismatches++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dmalu_in_if  op_if ();
  dmalu_out_if res_if ();

  decimal_mantissa_alu uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .res_o  (res_if)
  );

  mantissa_checker board = new();

  int src_idle_pct;
  int snk_idle_pct;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: ready toggles at the falling edge, results taken at the rising edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      board.check_result('{mant:   {res_if.res_word2, res_if.res_word1, res_if.res_word0},
                           scale:  res_if.scale_out,
                           rem:    res_if.remainder_out,
                           order:  res_if.order,
                           status: res_if.status});
    end
  end

  // Watchdog: gives up when nothing has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  function automatic op_item_t make_op(logic [OP_W-1:0] opcode, logic [MANT_W-1:0] a,
                                       logic [MANT_W-1:0] b, int scale, bit negative,
                                       int digit, int rem_in);
    op_item_t op;
    op.opcode   = opcode;
    op.a        = a;
    op.b        = b;
    op.scale    = SCALE_W'(scale);
    op.negative = negative;
    op.digit    = DIGIT_W'(digit);
    op.rem_in   = REM_W'(rem_in);
    return op;
  endfunction

  // Mantissas weighted toward the edges of the arithmetic
  function automatic logic [MANT_W-1:0] rand_mant();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MANT_ALL;
      2:       return MANT_ALL - MANT_W'($urandom_range(0, 3));
      3:       return MANT_W'($urandom_range(0, 25));
      4:       return MANT_TENTH + MANT_W'($urandom_range(0, 4)) - 96'd2;
      5:       return MANT_W'($urandom) << (32 * $urandom_range(0, 2));
      default: return {$urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic op_item_t rand_op();
    op_item_t op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) op.opcode = (pick < 2) ? OP_RSVD6 : OP_RSVD7;
    else          op.opcode = OP_W'($urandom_range(OP_ADD, OP_ROUND));
    op.a = rand_mant();
    op.b = ($urandom_range(0, 7) == 0) ? op.a : rand_mant();
    case ($urandom_range(0, 9))
      0:       op.scale = '0;
      1:       op.scale = MAX_SCALE;
      2:       op.scale = SCALE_W'($urandom_range(29, 31));
      default: op.scale = SCALE_W'($urandom_range(0, 28));
    endcase
    op.negative = 1'($urandom_range(0, 1));
    op.digit    = DIGIT_W'($urandom_range(0, 31));
    op.rem_in   = ($urandom_range(0, 3) == 0) ? REM_W'($urandom_range(0, 15))
                                              : REM_W'($urandom_range(0, 9));
    return op;
  endfunction

  // Entered and left at a falling edge; valid stays high into the next item
  task automatic send_op(op_item_t op);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      op_if.valid = 1'b0;
      @(negedge clk_i);
    end
    op_if.opcode       = op.opcode;
    op_if.a_word0      = op.a[31:0];
    op_if.a_word1      = op.a[63:32];
    op_if.a_word2      = op.a[95:64];
    op_if.b_word0      = op.b[31:0];
    op_if.b_word1      = op.b[63:32];
    op_if.b_word2      = op.b[95:64];
    op_if.scale_in     = op.scale;
    op_if.negative_in  = op.negative;
    op_if.round_digit  = op.digit;
    op_if.remainder_in = op.rem_in;
    op_if.valid        = 1'b1;
    do @(posedge clk_i); while (!op_if.ready);
    board.log_operation(op);
    @(negedge clk_i);
  endtask

  // Sender holds off until every outstanding result is back
  task automatic wait_for_results();
    op_if.valid = 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    repeat (count) send_op(rand_op());
  endtask

  task automatic send_directed();
    // carry, zero and borrow corners
    send_op(make_op(OP_ADD, MANT_ALL, MANT_ALL, 28, 0, 0, 0));
    send_op(make_op(OP_ADD, '0, '0, 0, 1, 0, 0));
    send_op(make_op(OP_SUB, '0, 96'd1, 3, 0, 0, 0));
    send_op(make_op(OP_SUB, MANT_ALL, MANT_ALL, 31, 1, 0, 15));
    // ordering
    send_op(make_op(OP_CMP, MANT_ALL, '0, 0, 0, 0, 0));
    send_op(make_op(OP_CMP, '0, MANT_ALL, 0, 0, 0, 0));
    send_op(make_op(OP_CMP, 96'h1234_5678_9abc_def0_0f1e_2d3c, 96'h1234_5678_9abc_def0_0f1e_2d3c,
                    7, 1, 0, 0));
    // times ten: at the scale limit, just fitting, just overflowing, scale out of range
    send_op(make_op(OP_MUL10, 96'd1, '0, 28, 0, 0, 0));
    send_op(make_op(OP_MUL10, MANT_TENTH, '0, 0, 0, 0, 0));
    send_op(make_op(OP_MUL10, MANT_TENTH + 96'd1, '0, 0, 0, 0, 0));
    send_op(make_op(OP_MUL10, 96'd5, '0, 31, 0, 0, 0));
    // divide by ten: scale zero, full carried remainder, remainder over nine, bad scale
    send_op(make_op(OP_DIV10, 96'd123, '0, 0, 0, 0, 9));
    send_op(make_op(OP_DIV10, MANT_ALL, '0, 28, 0, 0, 9));
    send_op(make_op(OP_DIV10, MANT_ALL, '0, 1, 0, 0, 15));
    send_op(make_op(OP_DIV10, 96'd12345, '0, 31, 0, 0, 0));
    // rounding: ties on odd and even, downward wrap, overflow with and without rescale
    send_op(make_op(OP_ROUND, 96'd3, '0, 4, 0, 5, 0));
    send_op(make_op(OP_ROUND, 96'd4, '0, 4, 0, 5, 0));
    send_op(make_op(OP_ROUND, 96'd3, '0, 4, 0, -5, 0));
    send_op(make_op(OP_ROUND, '0, '0, 2, 1, -9, 0));
    send_op(make_op(OP_ROUND, MANT_ALL, '0, 5, 0, 9, 0));
    send_op(make_op(OP_ROUND, MANT_ALL, '0, 0, 0, 6, 0));
    send_op(make_op(OP_ROUND, MANT_ALL, '0, 0, 1, 5, 0));
    send_op(make_op(OP_ROUND, 96'd7, '0, 1, 0, -16, 0));
    send_op(make_op(OP_ROUND, 96'd9, '0, 1, 0, 4, 0));
    // undefined opcodes
    send_op(make_op(OP_RSVD6, MANT_ALL, MANT_ALL, 9, 1, 9, 9));
    send_op(make_op(OP_RSVD7, MANT_ALL, '0, 31, 1, -9, 15));
  endtask

  initial begin
    rst_ni             = 1'b0;
    stall_cycles       = 0;
    src_idle_pct       = 6;
    snk_idle_pct       = 53;
    op_if.valid        = 1'b0;
    op_if.opcode       = OP_ADD;
    op_if.a_word0      = '0;
    op_if.a_word1      = '0;
    op_if.a_word2      = '0;
    op_if.b_word0      = '0;
    op_if.b_word1      = '0;
    op_if.b_word2      = '0;
    op_if.scale_in     = '0;
    op_if.negative_in  = 1'b0;
    op_if.round_digit  = '0;
    op_if.remainder_in = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // slow receiver
    send_directed();
    send_random(RANDOM_ITEMS / 3);
    wait_for_results();

    // slow sender
    src_idle_pct = 53;
    snk_idle_pct = 6;
    send_random(RANDOM_ITEMS / 3);
    wait_for_results();

    // back to back on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
